/* design/breath_noise_expander_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the breath noise expander unit.
// Each macro expects signals named clk and arst_n in the scope that uses it.
// ----------------------------------------------------------------------------
`ifndef BREATH_NOISE_EXPANDER_UNIT_ASSERT_SVH
`define BREATH_NOISE_EXPANDER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BNE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BNE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bne_pkg.sv */
// ----------------------------------------------------------------------------
// bne_pkg
// Types, constants and lookup tables shared by the breath noise expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bne_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF  = 24;

	localparam int CHAN_W    = 3;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 4;
	localparam int AMT_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THR_LEVEL = 4'd0,
		CFG_CUT_DEPTH = 4'd1,
		CFG_RISE_COEF = 4'd2,
		CFG_FALL_COEF = 4'd3
	} cfg_idx_t;

	localparam logic signed [CFG_W-1:0] THRESHOLD_RST = -16'sd10240;
	localparam logic signed [CFG_W-1:0] REDUCTION_RST = -16'sd3072;

	typedef struct packed {
		logic signed [CFG_W-1:0] thr_level;
		logic signed [CFG_W-1:0] cut_depth;
		logic [CFG_W-1:0]        rise_coef;
		logic [CFG_W-1:0]        fall_coef;
	} cfg_t;

	// dB per octave in Q8.8 and octaves per dB in Q16.
	localparam logic [10:0] DB_PER_LOG2 = 11'd1541;
	localparam logic [13:0] LOG2_PER_DB = 14'd10885;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ENV_MUL,
		ST_ENV_MAC,
		ST_ENV_FLR,
		ST_NORM,
		ST_DB,
		ST_AMT,
		ST_GDB,
		ST_X,
		ST_MANT,
		ST_PROD,
		ST_SHIFT,
		ST_OUT
	} state_t;

	// Fractional part of log2(1 + k/32) in Q16.
	function automatic logic [15:0] log2_lut(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd2909;
			5'd2:  v = 16'd5732;
			5'd3:  v = 16'd8473;
			5'd4:  v = 16'd11136;
			5'd5:  v = 16'd13727;
			5'd6:  v = 16'd16248;
			5'd7:  v = 16'd18704;
			5'd8:  v = 16'd21098;
			5'd9:  v = 16'd23433;
			5'd10: v = 16'd25711;
			5'd11: v = 16'd27936;
			5'd12: v = 16'd30109;
			5'd13: v = 16'd32234;
			5'd14: v = 16'd34312;
			5'd15: v = 16'd36346;
			5'd16: v = 16'd38336;
			5'd17: v = 16'd40286;
			5'd18: v = 16'd42196;
			5'd19: v = 16'd44068;
			5'd20: v = 16'd45904;
			5'd21: v = 16'd47705;
			5'd22: v = 16'd49472;
			5'd23: v = 16'd51207;
			5'd24: v = 16'd52911;
			5'd25: v = 16'd54584;
			5'd26: v = 16'd56229;
			5'd27: v = 16'd57845;
			5'd28: v = 16'd59434;
			5'd29: v = 16'd60997;
			5'd30: v = 16'd62534;
			5'd31: v = 16'd64047;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// 2^(k/32) in Q16, with one guard entry at the top.
	function automatic logic [17:0] exp2_lut(input logic [5:0] k);
		logic [17:0] v;
		case (k)
			6'd0:  v = 18'd65536;
			6'd1:  v = 18'd66971;
			6'd2:  v = 18'd68438;
			6'd3:  v = 18'd69936;
			6'd4:  v = 18'd71468;
			6'd5:  v = 18'd73032;
			6'd6:  v = 18'd74632;
			6'd7:  v = 18'd76266;
			6'd8:  v = 18'd77936;
			6'd9:  v = 18'd79642;
			6'd10: v = 18'd81386;
			6'd11: v = 18'd83169;
			6'd12: v = 18'd84990;
			6'd13: v = 18'd86851;
			6'd14: v = 18'd88752;
			6'd15: v = 18'd90696;
			6'd16: v = 18'd92682;
			6'd17: v = 18'd94711;
			6'd18: v = 18'd96785;
			6'd19: v = 18'd98905;
			6'd20: v = 18'd101070;
			6'd21: v = 18'd103284;
			6'd22: v = 18'd105545;
			6'd23: v = 18'd107856;
			6'd24: v = 18'd110218;
			6'd25: v = 18'd112631;
			6'd26: v = 18'd115098;
			6'd27: v = 18'd117618;
			6'd28: v = 18'd120194;
			6'd29: v = 18'd122825;
			6'd30: v = 18'd125515;
			6'd31: v = 18'd128263;
			6'd32: v = 18'd131072;
			default: v = 18'd131072;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/bne_if.sv */
// ----------------------------------------------------------------------------
// bne interfaces
// Sample, result and configuration channels of the breath noise expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bne_sample_if #(parameter int SAMPLE_BITS = bne_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic [bne_pkg::CHAN_W-1:0]    channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source(output valid, channel, sample_in, input ready);
	modport sink(input valid, channel, sample_in, output ready);
endinterface

interface bne_result_if #(parameter int SAMPLE_BITS = bne_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic [bne_pkg::CHAN_W-1:0]    channel_out;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [bne_pkg::AMT_W-1:0]     reduction_amount;

	modport source(output valid, channel_out, sample_out, reduction_amount, input ready);
	modport sink(input valid, channel_out, sample_out, reduction_amount, output ready);
endinterface

interface bne_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bne_pkg::CFG_IDX_W-1:0] index;
	logic [bne_pkg::CFG_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/bne_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bne_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bne_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	bne_cfg_if.sink       cfg,
	output bne_pkg::cfg_t regs
);

	bne_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.thr_level <= bne_pkg::THRESHOLD_RST;
			regs_q.cut_depth <= bne_pkg::REDUCTION_RST;
			regs_q.rise_coef <= '0;
			regs_q.fall_coef <= '0;
		end else if (cfg.valid) begin
			case (bne_pkg::cfg_idx_t'(cfg.index))
				bne_pkg::CFG_THR_LEVEL: regs_q.thr_level <= $signed(cfg.data);
				bne_pkg::CFG_CUT_DEPTH: regs_q.cut_depth <= $signed(cfg.data);
				bne_pkg::CFG_RISE_COEF: regs_q.rise_coef <= cfg.data;
				bne_pkg::CFG_FALL_COEF: regs_q.fall_coef <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/bne_state_mem.sv */
// ----------------------------------------------------------------------------
// bne_state_mem
// Per-channel state memory with a registered read port and per-entry valid
// bits, so that an entry never written reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bne_state_mem #(
	parameter int DEPTH = bne_pkg::MAX_CHANNELS_DEF,
	parameter int AW    = 3,
	parameter int EW    = bne_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [EW-1:0]             rd_env,
	output logic [bne_pkg::AMT_W-1:0] rd_amt,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [EW-1:0]             wr_env,
	input  logic [bne_pkg::AMT_W-1:0] wr_amt
);

	localparam int DW = EW + bne_pkg::AMT_W;

	logic [DW-1:0]    mem_q [DEPTH];
	logic [DW-1:0]    rd_data_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_env, wr_amt};
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign {rd_env, rd_amt} = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* design/bne_core.sv */
// ----------------------------------------------------------------------------
// bne_core
// Sequencer and datapath: reads a channel's state, updates envelope and
// reduction amount, writes them back and forms the scaled output sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bne_core #(
	parameter int MAX_CHANNELS = bne_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = bne_pkg::SAMPLE_BITS_DEF,
	parameter int AW           = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bne_sample_if.sink                 sample_ch,
	bne_result_if.source               result_ch,
	input  bne_pkg::cfg_t              cfg,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [SAMPLE_BITS-1:0]     rd_env,
	input  logic [bne_pkg::AMT_W-1:0]  rd_amt,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [SAMPLE_BITS-1:0]     wr_env,
	output logic [bne_pkg::AMT_W-1:0]  wr_amt
);

	localparam int SB  = SAMPLE_BITS;
	localparam int EW  = SB;
	localparam int ZW  = $clog2(EW);
	localparam int L2W = ZW + 17;
	localparam int PW  = SB + 17;
	localparam int RW  = SB + 22;
	localparam int CH  = bne_pkg::CHAN_W;

	localparam longint unsigned FLOOR_RAW =
		((64'd1 << (SB - 1)) + 64'd500000) / 64'd1000000;
	localparam logic [EW-1:0] ENV_FLOOR = (FLOOR_RAW < 64'd1) ? EW'(1) : EW'(FLOOR_RAW);
	localparam logic [RW-1:0] LIM_NEG   = RW'(1) << (SB - 1);
	localparam logic [RW-1:0] LIM_POS   = LIM_NEG - RW'(1);

	bne_pkg::state_t state_q, state_d;

	logic accept, load_out;

	// Item registers.
	logic [CH-1:0]           chan_q;
	logic [AW-1:0]           idx_q;
	logic                    neg_q;
	logic [SB-1:0]           mag_q;
	logic [EW-1:0]           env_q;
	logic [15:0]             amt_q;
	logic [15:0]             coef_q;
	logic [PW-1:0]           prod_q;
	logic [EW-1:0]           norm_q;
	logic [ZW-1:0]           z_q;
	logic signed [L2W-1:0]   l2_q;
	logic signed [L2W-1:0]   db_q;
	logic signed [16:0]      gdb_q;
	logic signed [7:0]       sh_q;
	logic [15:0]             f_q;
	logic [17:0]             m_q;
	logic [RW-1:0]           res_q;

	logic          out_vld_q;
	logic [CH-1:0] out_chan_q;
	logic [SB-1:0] out_smp_q;
	logic [15:0]   out_amt_q;

	// Channel folding and input magnitude.
	logic [AW-1:0] idx_d;
	logic [SB-1:0] mag_d;

	always_comb begin
		idx_d = '0;
		for (int i = 0; i < 8; i++) begin
			if (sample_ch.channel == CH'(i)) begin
				idx_d = AW'(i % MAX_CHANNELS);
			end
		end
	end

	assign mag_d = sample_ch.sample_in[SB-1] ? (~sample_ch.sample_in + 1'b1)
	                                         : sample_ch.sample_in;

	// Envelope filter.
	logic [15:0]   env_coef;
	logic [16:0]   env_comp;
	logic [PW-1:0] env_mac;
	logic [PW-1:0] env_shr;
	logic [EW-1:0] env_new;

	assign env_coef = (mag_q > rd_env) ? cfg.rise_coef : cfg.fall_coef;
	assign env_comp = 17'h10000 - {1'b0, coef_q};
	assign env_mac  = prod_q + PW'(env_q) * PW'(coef_q) + PW'(32768);
	assign env_shr  = prod_q >> 16;
	assign env_new  = (env_shr[EW-1:0] < ENV_FLOOR) ? ENV_FLOOR : env_shr[EW-1:0];

	// Leading-one search, up to eight bit positions per cycle.
	logic       norm_any;
	logic [2:0] norm_lz;
	logic [4:0] norm_k;
	logic signed [L2W-1:0] l2_d;

	always_comb begin
		norm_lz = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (norm_q[EW-1-i]) begin
				norm_lz = 3'(i);
			end
		end
	end

	assign norm_any = |norm_q[EW-1 -: 8];
	assign norm_k   = norm_q[EW-2 -: 5];
	assign l2_d     = $signed({{(L2W-16){1'b0}}, bne_pkg::log2_lut(norm_k)})
	                - $signed({1'b0, z_q, 16'h0});

	// Level in dB, rounded half away from zero.
	logic signed [L2W+11:0] pdb;
	logic [L2W+11:0]        pdb_mag;
	logic [L2W+11:0]        pdb_rnd;
	logic signed [L2W-1:0]  db_d;

	assign pdb     = l2_q * $signed({1'b0, bne_pkg::DB_PER_LOG2});
	assign pdb_mag = pdb[L2W+11] ? (~pdb + 1'b1) : pdb;
	assign pdb_rnd = (pdb_mag + (L2W+12)'(32768)) >> 16;
	assign db_d    = pdb[L2W+11] ? -$signed(pdb_rnd[L2W-1:0]) : $signed(pdb_rnd[L2W-1:0]);

	// Reduction amount update.
	logic        tgt;
	logic [15:0] amt_coef;
	logic [16:0] amt_comp;
	logic [32:0] amt_sum;
	logic [16:0] amt_shr;
	logic [15:0] amt_new;

	assign tgt      = db_q < L2W'(cfg.thr_level);
	assign amt_coef = tgt ? cfg.rise_coef : cfg.fall_coef;
	assign amt_comp = 17'h10000 - {1'b0, amt_coef};
	assign amt_sum  = (tgt ? {amt_comp, 16'h0} : 33'd0)
	                + 33'(amt_q) * 33'(amt_coef) + 33'd32768;
	assign amt_shr  = amt_sum[32:16];
	assign amt_new  = amt_shr[16] ? 16'hFFFF : amt_shr[15:0];

	// Gain in dB, Q8.8.
	logic signed [32:0] pg;
	logic [32:0]        pg_mag;
	logic [32:0]        pg_rnd;
	logic signed [16:0] gdb_d;

	assign pg     = $signed({1'b0, amt_q}) * cfg.cut_depth;
	assign pg_mag = pg[32] ? (~pg + 1'b1) : pg;
	assign pg_rnd = (pg_mag + 33'd32768) >> 16;
	assign gdb_d  = pg[32] ? -$signed(pg_rnd[16:0]) : $signed(pg_rnd[16:0]);

	// Gain as a Q16 power of two, offset so that its integer part is positive.
	logic signed [31:0] px;
	logic [31:0]        px_mag;
	logic [31:0]        px_rnd;
	logic signed [22:0] x_d;
	logic [22:0]        xp;

	assign px     = gdb_q * $signed({1'b0, bne_pkg::LOG2_PER_DB});
	assign px_mag = px[31] ? (~px + 1'b1) : px;
	assign px_rnd = (px_mag + 32'd128) >> 8;
	assign x_d    = px[31] ? -$signed(px_rnd[22:0]) : $signed(px_rnd[22:0]);
	assign xp     = x_d + 23'd4194304;

	// Mantissa by linear interpolation between table points.
	logic [4:0]  mk;
	logic [17:0] e0, e1, ed;
	logic [28:0] pm;
	logic [17:0] m_d;

	assign mk  = f_q[15:11];
	assign e0  = bne_pkg::exp2_lut({1'b0, mk});
	assign e1  = bne_pkg::exp2_lut(6'(mk) + 6'd1);
	assign ed  = e1 - e0;
	assign pm  = 29'(ed) * 29'(f_q[10:0]);
	assign m_d = e0 + 18'(pm >> 11);

	// Final scaling shift with rounding.
	logic [5:0]    sh_r;
	logic [5:0]    sh_l;
	logic [RW-1:0] res_sh;

	assign sh_r = sh_q[5:0];
	assign sh_l = 6'(-sh_q);

	always_comb begin
		if (sh_q > 8'sd0) begin
			res_sh = (res_q + (RW'(1) << (sh_r - 6'd1))) >> sh_r;
		end else begin
			res_sh = res_q << sh_l;
		end
	end

	// Saturation and sign restore.
	logic [RW-1:0] sat_mag;
	logic [SB-1:0] smp_d;

	always_comb begin
		if (neg_q) begin
			sat_mag = (res_q > LIM_NEG) ? LIM_NEG : res_q;
			smp_d   = ~sat_mag[SB-1:0] + 1'b1;
		end else begin
			sat_mag = (res_q > LIM_POS) ? LIM_POS : res_q;
			smp_d   = sat_mag[SB-1:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bne_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		load_out = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			bne_pkg::ST_IDLE: begin
				accept = sample_ch.valid;
				if (sample_ch.valid) begin
					state_d = bne_pkg::ST_READ;
				end
			end
			bne_pkg::ST_READ:    state_d = bne_pkg::ST_ENV_MUL;
			bne_pkg::ST_ENV_MUL: state_d = bne_pkg::ST_ENV_MAC;
			bne_pkg::ST_ENV_MAC: state_d = bne_pkg::ST_ENV_FLR;
			bne_pkg::ST_ENV_FLR: state_d = bne_pkg::ST_NORM;
			bne_pkg::ST_NORM: begin
				if (norm_q[EW-1]) begin
					state_d = bne_pkg::ST_DB;
				end
			end
			bne_pkg::ST_DB:      state_d = bne_pkg::ST_AMT;
			bne_pkg::ST_AMT: begin
				wr_en   = 1'b1;
				state_d = bne_pkg::ST_GDB;
			end
			bne_pkg::ST_GDB:     state_d = bne_pkg::ST_X;
			bne_pkg::ST_X:       state_d = bne_pkg::ST_MANT;
			bne_pkg::ST_MANT:    state_d = bne_pkg::ST_PROD;
			bne_pkg::ST_PROD:    state_d = bne_pkg::ST_SHIFT;
			bne_pkg::ST_SHIFT:   state_d = bne_pkg::ST_OUT;
			bne_pkg::ST_OUT: begin
				if (!out_vld_q || result_ch.ready) begin
					load_out = 1'b1;
					state_d  = bne_pkg::ST_IDLE;
				end
			end
			default:             state_d = bne_pkg::ST_IDLE;
		endcase
	end

	assign sample_ch.ready = (state_q == bne_pkg::ST_IDLE);
	assign rd_en           = accept;
	assign rd_addr         = idx_d;
	assign wr_addr         = idx_q;
	assign wr_env          = env_q;
	assign wr_amt          = amt_new;

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			bne_pkg::ST_IDLE: begin
				if (accept) begin
					chan_q <= sample_ch.channel;
					idx_q  <= idx_d;
					neg_q  <= sample_ch.sample_in[SB-1];
					mag_q  <= mag_d;
				end
			end
			bne_pkg::ST_READ: begin
				env_q  <= rd_env;
				amt_q  <= rd_amt;
				coef_q <= env_coef;
			end
			bne_pkg::ST_ENV_MUL: prod_q <= PW'(mag_q) * PW'(env_comp);
			bne_pkg::ST_ENV_MAC: prod_q <= env_mac;
			bne_pkg::ST_ENV_FLR: begin
				env_q  <= env_new;
				norm_q <= env_new;
				z_q    <= '0;
			end
			bne_pkg::ST_NORM: begin
				if (norm_q[EW-1]) begin
					l2_q <= l2_d;
				end else if (!norm_any) begin
					norm_q <= norm_q << 8;
					z_q    <= z_q + ZW'(8);
				end else begin
					norm_q <= norm_q << norm_lz;
					z_q    <= z_q + ZW'(norm_lz);
				end
			end
			bne_pkg::ST_DB:    db_q  <= db_d;
			bne_pkg::ST_AMT:   amt_q <= amt_new;
			bne_pkg::ST_GDB:   gdb_q <= gdb_d;
			bne_pkg::ST_X: begin
				// Shift count is 16 minus the integer part of the exponent.
				sh_q <= 8'sd80 - $signed({1'b0, xp[22:16]});
				f_q  <= xp[15:0];
			end
			bne_pkg::ST_MANT:  m_q   <= m_d;
			bne_pkg::ST_PROD:  res_q <= RW'(mag_q) * RW'(m_q);
			bne_pkg::ST_SHIFT: res_q <= res_sh;
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_chan_q <= chan_q;
			out_smp_q  <= smp_d;
			out_amt_q  <= amt_q;
		end
	end

	assign result_ch.valid            = out_vld_q;
	assign result_ch.channel_out      = out_chan_q;
	assign result_ch.sample_out       = $signed(out_smp_q);
	assign result_ch.reduction_amount = out_amt_q;

endmodule

`default_nettype wire

/* design/breath_noise_expander_unit.sv */
// ----------------------------------------------------------------------------
// breath_noise_expander_unit
// Per-channel downward expander with a peak envelope follower.
// ----------------------------------------------------------------------------
//
//  Channel    | Direction | Payload
//  -----------+-----------+------------------------------------------------
//  sample_ch  | sink      | channel, sample_in
//  result_ch  | source    | channel_out, sample_out, reduction_amount
//  cfg        | sink      | index, data (always ready)
//
// One sample is in flight at a time; a result is registered once its input
// has passed through every sequencer state. The leading-one search of the log
// stage repeats until the envelope is normalized, so it depends on the level.
// Reset clears all channel state at once through per-entry valid bits, so
// there is no clearing pass. A result left waiting in the output register
// does not block the next input transfer; only a second result stalls.
//
`timescale 1ns / 1ps
`default_nettype none

`include "breath_noise_expander_unit_assert.svh"

module breath_noise_expander_unit #(
	parameter int MAX_CHANNELS = bne_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = bne_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bne_sample_if.sink   sample_ch,
	bne_result_if.source result_ch,
	bne_cfg_if.sink      cfg
);

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	bne_pkg::cfg_t cfg_regs;

	// State memory access between the sequencer and the channel store.
	logic                      mem_rd_en;
	logic [AW-1:0]             mem_rd_addr;
	logic [SAMPLE_BITS-1:0]    mem_rd_env;
	logic [bne_pkg::AMT_W-1:0] mem_rd_amt;
	logic                      mem_wr_en;
	logic [AW-1:0]             mem_wr_addr;
	logic [SAMPLE_BITS-1:0]    mem_wr_env;
	logic [bne_pkg::AMT_W-1:0] mem_wr_amt;

	bne_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// Envelope and amount for every channel live in one small memory.
	bne_state_mem #(
		.DEPTH (MAX_CHANNELS),
		.AW    (AW),
		.EW    (SAMPLE_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_env  (mem_rd_env),
		.rd_amt  (mem_rd_amt),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_env  (mem_wr_env),
		.wr_amt  (mem_wr_amt)
	);

	// The sequencer reads the channel entry at the input transfer and writes
	// it back before it takes another sample, so no forwarding is needed.
	bne_core #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.AW           (AW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg_regs),
		.rd_en     (mem_rd_en),
		.rd_addr   (mem_rd_addr),
		.rd_env    (mem_rd_env),
		.rd_amt    (mem_rd_amt),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_env    (mem_wr_env),
		.wr_amt    (mem_wr_amt)
	);

	// A sample transfer closes the input until that sample is done.
	`BNE_ASSERT_NEXT(a_one_in_flight, sample_ch.valid && sample_ch.ready, !sample_ch.ready, "input reopened right after a transfer")

	// A state write-back happens only while busy, and only once per sample.
	`BNE_ASSERT_SAME(a_wb_busy, mem_wr_en, !sample_ch.ready, "state written back while idle")
	`BNE_ASSERT_NEXT(a_wb_once, mem_wr_en, !mem_wr_en && !sample_ch.ready, "state write-back repeated")

	// A threshold write lands in the register file.
	`BNE_ASSERT_NEXT(a_cfg_thr, cfg.valid && cfg.ready && (cfg.index == bne_pkg::CFG_THR_LEVEL), cfg_regs.thr_level == $past(cfg.data), "threshold write lost")

endmodule

`default_nettype wire
